>>> rtl/lcd_mode_sequencer_core_defines.svh
// Assertion macros for the LCD mode sequencer checker.
// Standalone header; no dependencies.
`ifndef LCD_MODE_SEQUENCER_CORE_DEFINES_SVH
`define LCD_MODE_SEQUENCER_CORE_DEFINES_SVH

// Hold the consequent in the same cycle as the antecedent.
`define LMS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Hold the consequent in the cycle after the antecedent.
`define LMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/lms_pkg.sv
// Types and constants for the LCD mode sequencer.
// No dependencies; used by the step logic, the top level, the checker and the testbench.
package lms_pkg;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   localparam logic [9:0] ACC_MAX           = 10'd1023;
   localparam logic [9:0] OAM_END           = 10'd77;
   localparam logic [9:0] XFER_END          = 10'd169;
   localparam logic [9:0] HBLANK_END        = 10'd201;
   localparam int         FRAME_VBLANK_CLKS = 456;
   localparam logic [7:0] LAST_VISIBLE_LINE = 8'd143;
   localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
   localparam logic [7:0] LAST_LINE         = 8'd152;
   localparam logic [9:0] VBLANK_LINE_CLKS  =
      10'(FRAME_VBLANK_CLKS / (int'(LAST_LINE) - int'(FIRST_VBLANK_LINE)));

   typedef struct packed {
      logic [7:0] clocks_elapsed;
      logic       lcd_enabled;
      logic [7:0] line_compare;
   } req_type;

   typedef struct packed {
      logic [7:0] line_number;
      logic [1:0] lcd_mode;
      logic       coincidence;
      logic       vblank_request;
      logic       stat_request;
   } rsp_type;

   typedef struct packed {
      logic [9:0] acc;
      logic [7:0] line;
      mode_type   mode;
   } state_type;

endpackage

>>> rtl/lms_step.sv
// Next-state and result logic for one sequencer transaction.
// Depends on lms_pkg.
module lms_step (
   input  lms_pkg::state_type state,
   input  lms_pkg::req_type   req,
   output lms_pkg::state_type state_next,
   output lms_pkg::rsp_type   rsp
);

   logic [10:0] sum;
   logic [9:0]  acc_sat;
   logic        coin;
   logic        vbl;

   always_comb begin
      sum        = {1'b0, state.acc} + {3'b000, req.clocks_elapsed};
      acc_sat    = sum[10] ? lms_pkg::ACC_MAX : sum[9:0];
      state_next = state;
      coin       = 1'b0;
      vbl        = 1'b0;
      if (req.lcd_enabled) begin
         state_next.acc = acc_sat;
         coin           = (state.line == req.line_compare);
         unique case (state.mode)
            lms_pkg::MODE_HBLANK: begin
               if (acc_sat >= lms_pkg::HBLANK_END) begin
                  state_next.mode = (state.line == lms_pkg::LAST_VISIBLE_LINE) ?
                                    lms_pkg::MODE_VBLANK : lms_pkg::MODE_OAM;
                  state_next.line = state.line + 8'd1;
                  state_next.acc  = '0;
               end
            end
            lms_pkg::MODE_VBLANK: begin
               vbl = 1'b1;
               if (acc_sat >= lms_pkg::VBLANK_LINE_CLKS) begin
                  if (state.line == lms_pkg::LAST_LINE) begin
                     state_next.line = '0;
                     state_next.mode = lms_pkg::MODE_OAM;
                  end else begin
                     state_next.line = state.line + 8'd1;
                  end
                  state_next.acc = '0;
               end
            end
            lms_pkg::MODE_OAM: begin
               if (acc_sat >= lms_pkg::OAM_END) begin
                  state_next.mode = lms_pkg::MODE_XFER;
               end
            end
            lms_pkg::MODE_XFER: begin
               if (acc_sat >= lms_pkg::XFER_END) begin
                  state_next.mode = lms_pkg::MODE_HBLANK;
               end
            end
            default: begin
               state_next = state;
            end
         endcase
      end
      rsp.line_number    = state_next.line;
      rsp.lcd_mode       = state_next.mode;
      rsp.coincidence    = coin;
      rsp.vblank_request = vbl;
      rsp.stat_request   = coin;
   end

endmodule

>>> rtl/lcd_mode_sequencer_core.sv
// LCD line and mode sequencer: top level with state and result registers.
// Depends on lms_pkg and lms_step.
//
// Usage:
//   req channel: one transaction per emulated CPU step, carrying the clocks
//   elapsed, the LCD enable bit and the line compare value.
//   rsp channel: one transaction per request with the scan line and mode
//   after the step plus coincidence, V-blank and STAT request flags.
//   Result: registered; it appears in the cycle after the request is accepted.
//   Throughput: one transaction per cycle while req_stall is low; the line, mode
//   and accumulator registers are updated by a single pass of compare-and-add
//   logic, so the next request sees the new state in the following cycle.
//   Stall: the result register is refilled in the cycle it is taken; while
//   it holds an untaken result and rsp_stall is high, req_stall is raised
//   and both the result and the sequencer state hold.
//   Reset: synchronous, active high; clears the accumulator, the scan line
//   and the mode (H-blank) and empties the result register.
//   A request with the LCD disabled leaves the state unchanged and returns
//   the current line and mode with all flags low.
module lcd_mode_sequencer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lms_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lms_pkg::rsp_type rsp_data
);

   lms_pkg::state_type state_ff;
   lms_pkg::state_type state_in;
   lms_pkg::state_type state_step;
   lms_pkg::rsp_type   rsp_step;
   lms_pkg::rsp_type   rsp_data_ff;
   lms_pkg::rsp_type   rsp_data_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               req_take;

   lms_step u_lms_step (
      .state      (state_ff),
      .req        (req_data),
      .state_next (state_step),
      .rsp        (rsp_step)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (req_take) begin
         state_in     = state_step;
         rsp_data_in  = rsp_step;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.acc  <= '0;
         state_ff.line <= '0;
         state_ff.mode <= lms_pkg::MODE_HBLANK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/lms_checker.sv
// Port-level assertions for the LCD mode sequencer, bound to the top level.
// Depends on lms_pkg and lcd_mode_sequencer_core_defines.svh.
`include "lcd_mode_sequencer_core_defines.svh"

module lms_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lms_pkg::rsp_type rsp_data
);

   logic req_take;
   logic rsp_held;
   logic stat_ok;
   logic vbl_step;
   logic vbl_mode_ok;
   logic visible;
   logic visible_line_ok;

   assign req_take        = req_valid & ~req_stall;
   assign rsp_held        = rsp_valid & rsp_stall;
   assign stat_ok         = rsp_data.stat_request == rsp_data.coincidence;
   assign vbl_step        = rsp_valid & rsp_data.vblank_request;
   assign vbl_mode_ok     = (rsp_data.lcd_mode == lms_pkg::MODE_VBLANK) |
                            (rsp_data.lcd_mode == lms_pkg::MODE_OAM);
   assign visible         = rsp_valid & (rsp_data.lcd_mode != lms_pkg::MODE_VBLANK);
   assign visible_line_ok = rsp_data.line_number <= lms_pkg::LAST_VISIBLE_LINE;

   `LMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data), "stalled result changed")
   `LMS_ASSERT_NEXT(a_one_cycle, clock, reset, req_take, rsp_valid, "no result after transaction")
   `LMS_ASSERT_SAME(a_stat_coin, clock, reset, rsp_valid, stat_ok, "STAT differs from coincidence")
   `LMS_ASSERT_SAME(a_vbl_mode, clock, reset, vbl_step, vbl_mode_ok, "V-blank step left a wrong mode")
   `LMS_ASSERT_SAME(a_vis_line, clock, reset, visible, visible_line_ok, "visible mode on V-blank line")

endmodule

bind lcd_mode_sequencer_core lms_checker u_lms_checker (.*);

>>> tb/sv/tb_lcd_mode_sequencer_core.sv
// Self-checking testbench for lcd_mode_sequencer_core: line, mode and flag tracking
// over directed steps and 1250 random CPU steps with random stalls.
// Depends on lms_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_lcd_mode_sequencer_core;

   class lcd_step_checker;
      logic [9:0]        acc;
      logic [7:0]        line;
      lms_pkg::mode_type mode;
      lms_pkg::rsp_type  expected_status[$];
      int                mismatches;
      int                steps_noted;
      int                results_seen;
      int                coincidences;
      int                vblank_steps;
      int                frame_wraps;

      function void clear_state();
         acc = '0;
         line = '0;
         mode = lms_pkg::MODE_HBLANK;
         expected_status.delete();
      endfunction

      function void note_step(lms_pkg::req_type r);
         logic [10:0]      sum;
         logic             coin;
         logic             vbl;
         lms_pkg::rsp_type exp;
         coin = 1'b0;
         vbl = 1'b0;
         if (r.lcd_enabled) begin
            sum = {1'b0, acc} + {3'b000, r.clocks_elapsed};
            acc = (sum > {1'b0, lms_pkg::ACC_MAX}) ? lms_pkg::ACC_MAX : sum[9:0];
            coin = (line == r.line_compare);
            case (mode)
               lms_pkg::MODE_HBLANK: begin
                  if (acc >= lms_pkg::HBLANK_END) begin
                     mode = (line == lms_pkg::LAST_VISIBLE_LINE) ?
                            lms_pkg::MODE_VBLANK : lms_pkg::MODE_OAM;
                     line = line + 8'd1;
                     acc = '0;
                  end
               end
               lms_pkg::MODE_VBLANK: begin
                  vbl = 1'b1;
                  if (acc >= lms_pkg::VBLANK_LINE_CLKS) begin
                     if (line == lms_pkg::LAST_LINE) begin
                        line = '0;
                        mode = lms_pkg::MODE_OAM;
                        frame_wraps++;
                     end else begin
                        line = line + 8'd1;
                     end
                     acc = '0;
                  end
               end
               lms_pkg::MODE_OAM: begin
                  if (acc >= lms_pkg::OAM_END) mode = lms_pkg::MODE_XFER;
               end
               default: begin
                  if (acc >= lms_pkg::XFER_END) mode = lms_pkg::MODE_HBLANK;
               end
            endcase
         end
         exp.line_number    = line;
         exp.lcd_mode       = mode;
         exp.coincidence    = coin;
         exp.vblank_request = vbl;
         exp.stat_request   = coin;
         expected_status.push_back(exp);
         steps_noted++;
         coincidences += coin;
         vblank_steps += vbl;
      endfunction

      function void check_result(lms_pkg::rsp_type got);
         lms_pkg::rsp_type exp;
         results_seen++;
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected transaction line=%0d mode=%0d flags=%b%b%b",
                        got.line_number, got.lcd_mode, got.coincidence,
                        got.vblank_request, got.stat_request);
            return;
         end
         exp = expected_status.pop_front();
         if (got.line_number !== exp.line_number || got.lcd_mode !== exp.lcd_mode ||
             got.coincidence !== exp.coincidence ||
             got.vblank_request !== exp.vblank_request ||
             got.stat_request !== exp.stat_request) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: result %0d exp line=%0d mode=%0d c/v/s=%b%b%b",
                         " got line=%0d mode=%0d c/v/s=%b%b%b"},
                        results_seen, exp.line_number, exp.lcd_mode, exp.coincidence,
                        exp.vblank_request, exp.stat_request, got.line_number,
                        got.lcd_mode, got.coincidence, got.vblank_request,
                        got.stat_request);
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   lms_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   lms_pkg::rsp_type rsp_data;
   logic             calm = 1'b0;

   lcd_step_checker tracker = new();

   lcd_mode_sequencer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 38);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_result(rsp_data);
   end

   function automatic lms_pkg::req_type make_step(logic [7:0] clk_count, logic en,
                                                  logic [7:0] cmp);
      lms_pkg::req_type r;
      r.clocks_elapsed = clk_count;
      r.lcd_enabled    = en;
      r.line_compare   = cmp;
      return r;
   endfunction

   task automatic send_step(lms_pkg::req_type r);
      while (!calm && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      tracker.note_step(r);
   endtask

   task automatic send_random_step();
      logic [7:0] clk_count;
      logic [7:0] cmp;
      logic       en;
      int         pick;
      en = ($urandom_range(99) >= 8);
      clk_count = ($urandom_range(99) < 40) ? 8'($urandom_range(60)) :
                                              8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 50)
         cmp = tracker.line;
      else if (pick < 60) begin
         case ($urandom_range(3))
            0: cmp = 8'd0;
            1: cmp = 8'd255;
            2: cmp = lms_pkg::LAST_VISIBLE_LINE;
            default: cmp = lms_pkg::LAST_LINE;
         endcase
      end else
         cmp = 8'($urandom_range(255));
      send_step(make_step(clk_count, en, cmp));
   endtask

   initial begin
      int waited;
      tracker.clear_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // line 0, H-blank: disabled, zero clocks, thresholds hit exactly
      send_step(make_step(8'd255, 1'b0, 8'd0));
      send_step(make_step(8'd0, 1'b1, 8'd0));
      send_step(make_step(8'd200, 1'b1, 8'd255));
      send_step(make_step(8'd1, 1'b1, 8'd0));
      send_step(make_step(8'd76, 1'b1, 8'd1));
      send_step(make_step(8'd1, 1'b1, 8'd1));
      send_step(make_step(8'd91, 1'b1, 8'd255));
      send_step(make_step(8'd1, 1'b1, 8'd1));
      send_step(make_step(8'd255, 1'b0, 8'd1));
      send_step(make_step(8'd255, 1'b1, 8'd128));
      send_step(make_step(8'd255, 1'b1, 8'd2));
      send_step(make_step(8'd255, 1'b1, 8'd127));
      send_step(make_step(8'd255, 1'b1, 8'd2));
      send_step(make_step(8'd170, 1'b1, 8'd3));
      send_step(make_step(8'd85, 1'b0, 8'd3));
      send_step(make_step(8'd0, 1'b1, 8'd3));

      for (int i = 0; i < 1250; i++) begin
         calm = (i >= 500 && i < 700);
         send_random_step();
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      waited = 0;
      while (tracker.expected_status.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);

      $display("Covered %0d steps, %0d results: %0d coincidences, %0d V-blank steps,",
               tracker.steps_noted, tracker.results_seen, tracker.coincidences,
               tracker.vblank_steps);
      $display("%0d frame wraps; mismatches: %0d, results still outstanding: %0d.",
               tracker.frame_wraps, tracker.mismatches, tracker.expected_status.size());
      if (tracker.mismatches == 0 && tracker.expected_status.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout: run did not complete.");
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/lms_pkg.sv
rtl/lms_step.sv
rtl/lcd_mode_sequencer_core.sv
rtl/lms_checker.sv
tb/sv/tb_lcd_mode_sequencer_core.sv
